FILE: hdl/pftr_pkg.sv
// ----------------------------------------------------------------------------
// pftr_pkg
// Shared types, geometry constants and the 5x7 font for the page framebuffer
// text renderer.
// ----------------------------------------------------------------------------
package pftr_pkg;

  // panel geometry
  localparam int WIDTH_PX    = 128;
  localparam int HEIGHT_PX   = 64;
  localparam int PAGE_COUNT  = (HEIGHT_PX + 7) / 8;
  localparam int STORE_BYTES = WIDTH_PX * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int FULL_ADDR_W = 13;   // holds column + page * width for any page
  localparam int BIDX_W      = 10;

  localparam logic [8:0] WIDTH_9  = 9'(WIDTH_PX);
  localparam logic [8:0] HEIGHT_9 = 9'(HEIGHT_PX);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
  localparam logic [BIDX_W:0] STORE_BYTES_B = (BIDX_W + 1)'(STORE_BYTES);

  // glyph geometry
  localparam int GLYPH_W = 5;
  localparam int GLYPH_H = 7;
  localparam logic [7:0] ADVANCE  = 8'd6;
  localparam logic [8:0] GLYPH_W9 = 9'(GLYPH_W);
  localparam logic [2:0] COL_LAST_GLYPH = 3'(GLYPH_W - 1);
  localparam logic [2:0] HGT_GLYPH = 3'(GLYPH_H);
  localparam logic [2:0] HGT_PIXEL = 3'd1;

  typedef logic [GLYPH_W-1:0][7:0] glyph_t;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CHAR  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_WRITE,
    ST_OP_CLR,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the accepted word
    logic rd_en;     // store read, data registered
    logic wr_en;     // masked write-back of the current byte
    logic step;      // move to next page / column
    logic clr_wr;    // clear sweep write
    logic load_out;  // capture result word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic draw;
    logic last_step;
    logic clr_last;
  } stat_t;

  // Column bits of each glyph, column 0 in the low byte, bit 0 = top row.
  function automatic glyph_t glyph_bits(input logic [7:0] code);
    glyph_t g;
    unique case (code)
      "-":     g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      ".":     g = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
      ":":     g = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
      "%":     g = {8'h23, 8'h13, 8'h08, 8'h64, 8'h62};
      "0":     g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
      "1":     g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
      "2":     g = {8'h46, 8'h49, 8'h49, 8'h51, 8'h62};
      "3":     g = {8'h36, 8'h49, 8'h49, 8'h41, 8'h22};
      "4":     g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
      "5":     g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
      "6":     g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
      "7":     g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
      "8":     g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      "9":     g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
      "A":     g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      "C":     g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
      "D":     g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
      "E":     g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
      "G":     g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
      "H":     g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      "I":     g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      "K":     g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
      "L":     g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
      "M":     g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      "N":     g = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
      "O":     g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      "P":     g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
      "R":     g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
      "S":     g = {8'h32, 8'h49, 8'h49, 8'h49, 8'h26};
      "T":     g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      "U":     g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      "X":     g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      "Y":     g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      "Z":     g = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
      default: g = '0;  // space and unknown codes: blank cell
    endcase
    return g;
  endfunction

endpackage

FILE: hdl/pftr_ctrl.sv
// ----------------------------------------------------------------------------
// pftr_ctrl
// Sequencer: clear sweep, per-byte read-modify-write loop, result handoff.
// ----------------------------------------------------------------------------
module pftr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  pftr_pkg::stat_t stat,
  output pftr_pkg::cmd_t  cmd
);

  pftr_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == pftr_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pftr_pkg::ST_INIT_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pftr_pkg::ST_INIT_CLR: if (stat.clr_last) state_nxt = pftr_pkg::ST_IDLE;
      pftr_pkg::ST_IDLE:     if (in_tvalid) state_nxt = pftr_pkg::ST_DISPATCH;
      pftr_pkg::ST_DISPATCH: begin
        unique case (stat.op)
          pftr_pkg::OP_CLEAR: state_nxt = pftr_pkg::ST_OP_CLR;
          pftr_pkg::OP_CHAR:  state_nxt = stat.draw ? pftr_pkg::ST_READ : pftr_pkg::ST_DONE;
          pftr_pkg::OP_SET,
          pftr_pkg::OP_READ:  state_nxt = pftr_pkg::ST_READ;
        endcase
      end
      pftr_pkg::ST_READ:
        state_nxt = (stat.op == pftr_pkg::OP_READ) ? pftr_pkg::ST_DONE : pftr_pkg::ST_WRITE;
      pftr_pkg::ST_WRITE:
        state_nxt = stat.last_step ? pftr_pkg::ST_DONE : pftr_pkg::ST_READ;
      pftr_pkg::ST_OP_CLR:   if (stat.clr_last) state_nxt = pftr_pkg::ST_DONE;
      pftr_pkg::ST_DONE:     if (out_free) state_nxt = pftr_pkg::ST_IDLE;
      default:               state_nxt = pftr_pkg::ST_INIT_CLR;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      pftr_pkg::ST_INIT_CLR,
      pftr_pkg::ST_OP_CLR: cmd.clr_wr = 1'b1;
      pftr_pkg::ST_IDLE:   cmd.load = in_tvalid;
      pftr_pkg::ST_READ:   cmd.rd_en = 1'b1;
      pftr_pkg::ST_WRITE: begin
        cmd.wr_en = 1'b1;
        cmd.step  = !stat.last_step;
      end
      pftr_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/pftr_datapath.sv
// ----------------------------------------------------------------------------
// pftr_datapath
// Framebuffer store, string cursor, glyph byte builder and result register.
// ----------------------------------------------------------------------------
module pftr_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  pftr_pkg::cmd_t  cmd,
  output pftr_pkg::stat_t stat,
  input  logic [1:0]      in_op,
  input  logic [7:0]      in_x,
  input  logic [7:0]      in_y,
  input  logic            in_on,
  input  logic [7:0]      in_ch,
  input  logic            in_start,
  input  logic [pftr_pkg::BIDX_W-1:0] in_bidx,
  output logic [7:0]      read_data,
  output logic            drawn
);

  logic [7:0] mem [pftr_pkg::STORE_BYTES];

  // string state
  logic [7:0] cursor_r, row_r;
  logic       full_r;

  // current item
  pftr_pkg::op_t    op_r;
  pftr_pkg::glyph_t glyph_r;
  logic [7:0]       base_col_r, base_row_r;
  logic [2:0]       hgt_r;
  logic [2:0]       col_last_r;
  logic [2:0]       col_idx_r;
  logic             page_sel_r;
  logic             draw_r;
  logic [pftr_pkg::BIDX_W-1:0] bidx_r;

  logic [7:0] rdata_r;
  logic [7:0] read_data_r;
  logic       drawn_r;
  logic [pftr_pkg::ADDR_W-1:0] clr_cnt_r;

  // load-time cursor logic
  logic [7:0] eff_col, eff_row, cur_adv;
  logic       eff_full, full_adv;

  assign eff_col  = in_start ? in_x : cursor_r;
  assign eff_row  = in_start ? in_y : row_r;
  assign eff_full = in_start ? 1'b0 : full_r;
  assign cur_adv  = eff_col + pftr_pkg::ADVANCE;
  assign full_adv = ({1'b0, cur_adv} + pftr_pkg::GLYPH_W9) >= pftr_pkg::WIDTH_9;

  // byte builder for the current column / page
  logic [7:0] px, row_end;
  logic [4:0] page0, page1, page;
  logic       page_same, col_ok;
  logic [7:0] mask, wdata;
  logic [pftr_pkg::FULL_ADDR_W-1:0] addr_full;
  logic [pftr_pkg::ADDR_W-1:0] rmw_addr, rd_addr, wr_addr;
  logic [7:0] row, rel;
  logic       bidx_ok;

  assign px        = base_col_r + 8'(col_idx_r);
  assign row_end   = base_row_r + 8'(hgt_r - 3'd1);
  assign page0     = base_row_r[7:3];
  assign page1     = row_end[7:3];
  assign page_same = (page0 == page1);
  assign page      = page_sel_r ? page1 : page0;
  assign col_ok    = {1'b0, px} < pftr_pkg::WIDTH_9;
  assign addr_full = pftr_pkg::FULL_ADDR_W'(px)
                   + pftr_pkg::FULL_ADDR_W'(page) * pftr_pkg::FULL_ADDR_W'(pftr_pkg::WIDTH_PX);
  assign rmw_addr  = addr_full[pftr_pkg::ADDR_W-1:0];
  assign bidx_ok   = {1'b0, bidx_r} < pftr_pkg::STORE_BYTES_B;

  always_comb begin
    mask  = '0;
    wdata = '0;
    row   = '0;
    rel   = '0;
    for (int b = 0; b < 8; b++) begin
      row      = {page, 3'(b)};
      rel      = row - base_row_r;
      mask[b]  = col_ok && (rel < 8'(hgt_r)) && ({1'b0, row} < pftr_pkg::HEIGHT_9);
      wdata[b] = glyph_r[col_idx_r][rel[2:0]];
    end
  end

  assign rd_addr = (op_r == pftr_pkg::OP_READ) ? pftr_pkg::ADDR_W'(bidx_r) : rmw_addr;
  assign wr_addr = cmd.clr_wr ? clr_cnt_r : rmw_addr;

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[wr_addr] <= '0;
    end else if (cmd.wr_en && (mask != '0)) begin
      mem[wr_addr] <= (rdata_r & ~mask) | (wdata & mask);
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r   <= '0;
      row_r      <= '0;
      full_r     <= 1'b0;
      clr_cnt_r  <= '0;
      col_idx_r  <= '0;
      page_sel_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= (clr_cnt_r == pftr_pkg::LAST_ADDR) ? '0 : clr_cnt_r + 1'b1;
      end
      if (cmd.load) begin
        col_idx_r  <= '0;
        page_sel_r <= 1'b0;
        if (pftr_pkg::op_t'(in_op) == pftr_pkg::OP_CHAR) begin
          cursor_r <= eff_full ? eff_col : cur_adv;
          row_r    <= eff_row;
          full_r   <= eff_full ? 1'b1 : full_adv;
        end
      end else if (cmd.step) begin
        if (!page_sel_r && !page_same) begin
          page_sel_r <= 1'b1;
        end else begin
          page_sel_r <= 1'b0;
          col_idx_r  <= col_idx_r + 3'd1;
        end
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= pftr_pkg::op_t'(in_op);
      bidx_r <= in_bidx;
      draw_r <= !eff_full;
      if (pftr_pkg::op_t'(in_op) == pftr_pkg::OP_CHAR) begin
        base_col_r <= eff_col;
        base_row_r <= eff_row;
        glyph_r    <= pftr_pkg::glyph_bits(in_ch);
        hgt_r      <= pftr_pkg::HGT_GLYPH;
        col_last_r <= pftr_pkg::COL_LAST_GLYPH;
      end else begin
        // single pixel: a one-column, one-row cell
        base_col_r <= in_x;
        base_row_r <= in_y;
        glyph_r    <= pftr_pkg::glyph_t'({7'd0, in_on});
        hgt_r      <= pftr_pkg::HGT_PIXEL;
        col_last_r <= '0;
      end
    end
    if (cmd.load_out) begin
      read_data_r <= ((op_r == pftr_pkg::OP_READ) && bidx_ok) ? rdata_r : '0;
      drawn_r     <= (op_r == pftr_pkg::OP_CHAR) && draw_r;
    end
  end

  assign stat.op        = op_r;
  assign stat.draw      = draw_r;
  assign stat.last_step = (col_idx_r == col_last_r) && (page_sel_r || page_same);
  assign stat.clr_last  = (clr_cnt_r == pftr_pkg::LAST_ADDR);

  assign read_data = read_data_r;
  assign drawn     = drawn_r;

endmodule

FILE: hdl/page_framebuffer_text_renderer.sv
// ----------------------------------------------------------------------------
// page_framebuffer_text_renderer
// Monochrome page-mode framebuffer with pixel, 5x7 text, clear and readback.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : command words. in_tuser carries the op (set pixel, string char,
//           clear all, read byte); in_tdata carries the operands.
//   out_* : exactly one result word per command, in command order.
//   Store is 1024 bytes (128 x 64 px), one byte per column and 8-row page,
//   bit 0 = top row of the page.
// Sequence (one command at a time, each store byte read, then written back):
// an accepted word passes DISPATCH, its op's states and DONE, which sets
// out_tvalid once the output register is free, then IDLE with in_tready high:
//   read byte   : READ
//   set pixel   : READ, WRITE
//   string char : READ, WRITE for each byte touched, up to 10 bytes;
//                 none when the line is already full
//   clear all   : OP_CLR sweep over all 1024 bytes, one store byte per cycle
// Reset: rst_n low clears the cursor state, then a sweep zeroes all 1024
//   store bytes; in_tready stays low until it finishes.
// Stall: a finished result sits in the output register; the next command is
//   accepted and worked on meanwhile, and only its handoff waits for
//   out_tready.
// ----------------------------------------------------------------------------
module page_framebuffer_text_renderer (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // x[7:0], y[15:8], on[16], ch[24:17],
                                  // start_string[25], byte_index[35:26], 0
  input  logic [1:0]  in_tuser,   // op[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // read_data[7:0], drawn[8], 0
);

  pftr_pkg::cmd_t  cmd;
  pftr_pkg::stat_t stat;
  logic [7:0]      read_data;
  logic            drawn;

  // sequencer
  pftr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // store, cursor and byte builder
  pftr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (in_tuser),
    .in_x      (in_tdata[7:0]),
    .in_y      (in_tdata[15:8]),
    .in_on     (in_tdata[16]),
    .in_ch     (in_tdata[24:17]),
    .in_start  (in_tdata[25]),
    .in_bidx   (in_tdata[35:26]),
    .read_data (read_data),
    .drawn     (drawn)
  );

  assign out_tdata = {7'd0, drawn, read_data};

endmodule

FILE: hdl/pftr_checker.sv
// ----------------------------------------------------------------------------
// pftr_checker
// Port-level checks on the framebuffer text renderer.
// ----------------------------------------------------------------------------
module pftr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // nothing accepted or shown right after reset (clear sweep running)
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_tready && !out_tvalid)
    else $error("activity right after reset");

  // one command at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken back to back");

  // a drawn character never carries read data, and padding stays zero
  a_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:9] == 7'd0) && (!out_tdata[8] || (out_tdata[7:0] == 8'd0)))
    else $error("malformed result word");

endmodule

bind page_framebuffer_text_renderer pftr_checker u_pftr_checker (.*);

FILE: test/tb_page_framebuffer_text_renderer.sv
// ----------------------------------------------------------------------------
// tb_page_framebuffer_text_renderer
// Self-checking bench for the page framebuffer text renderer. Command words
// go in through the input stream. A shadow framebuffer with its own cursor
// state predicts every result word. The store is observed only through
// read-byte commands, so reads are aimed mostly at freshly drawn areas.
// ----------------------------------------------------------------------------
module tb_page_framebuffer_text_renderer;
  timeunit 1ns;
  timeprecision 1ps;

  import pftr_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 40;         // quiet tail to catch stray result words
  localparam int MAX_GAP       = 20;         // cap on one sender idle stretch

  // local text geometry
  localparam int CELL_COLS    = 5;
  localparam int CELL_ROWS    = 7;
  localparam int CELL_ADVANCE = 6;

  // every glyph the font knows, blank first
  localparam string FONT_CHARS = " -.:%0123456789ACDEGHIKLMNOPRSTUXYZ";

  // one command word, unpacked
  typedef struct {
    op_t        op;
    logic [7:0] x;
    logic [7:0] y;
    logic       on;
    logic [7:0] ch;
    logic       start;
    logic [9:0] bidx;
  } cmd_word_t;

  // one result word
  typedef struct {
    logic [7:0] read_data;
    logic       drawn;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // x[7:0], y[15:8], on[16], ch[24:17],
                                // start_string[25], byte_index[35:26], 0
  logic [1:0]  in_tuser = '0;   // op[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // read_data[7:0], drawn[8], 0

  // shadow of the block's state
  logic [7:0] shadow_fb [STORE_BYTES];
  logic [7:0] pen_col;
  logic [7:0] pen_row;
  logic       row_full;

  result_word_t pending_results[$];

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int words_sent      = 0;
  int results_seen    = 0;
  int mismatch_count  = 0;
  int cycle_count     = 0;

  page_framebuffer_text_renderer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Font: five column bytes per glyph, column 0 in the top byte, bit 0 = top
  // row. Anything not listed (space, control codes, 128 and up) is blank.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] font_col(input logic [7:0] code, input int c);
    logic [39:0] cols;
    case (code)
      "-":     cols = 40'h08_08_08_08_08;
      ".":     cols = 40'h00_60_60_00_00;
      ":":     cols = 40'h00_36_36_00_00;
      "%":     cols = 40'h62_64_08_13_23;
      "0":     cols = 40'h3E_51_49_45_3E;
      "1":     cols = 40'h00_42_7F_40_00;
      "2":     cols = 40'h62_51_49_49_46;
      "3":     cols = 40'h22_41_49_49_36;
      "4":     cols = 40'h18_14_12_7F_10;
      "5":     cols = 40'h27_45_45_45_39;
      "6":     cols = 40'h3C_4A_49_49_30;
      "7":     cols = 40'h01_71_09_05_03;
      "8":     cols = 40'h36_49_49_49_36;
      "9":     cols = 40'h06_49_49_29_1E;
      "A":     cols = 40'h7E_11_11_11_7E;
      "C":     cols = 40'h3E_41_41_41_22;
      "D":     cols = 40'h7F_41_41_22_1C;
      "E":     cols = 40'h7F_49_49_49_41;
      "G":     cols = 40'h3E_41_49_49_7A;
      "H":     cols = 40'h7F_08_08_08_7F;
      "I":     cols = 40'h00_41_7F_41_00;
      "K":     cols = 40'h7F_08_14_22_41;
      "L":     cols = 40'h7F_40_40_40_40;
      "M":     cols = 40'h7F_02_0C_02_7F;
      "N":     cols = 40'h7F_04_08_10_7F;
      "O":     cols = 40'h3E_41_41_41_3E;
      "P":     cols = 40'h7F_09_09_09_06;
      "R":     cols = 40'h7F_09_19_29_46;
      "S":     cols = 40'h26_49_49_49_32;
      "T":     cols = 40'h01_01_7F_01_01;
      "U":     cols = 40'h3F_40_40_40_3F;
      "X":     cols = 40'h63_14_08_14_63;
      "Y":     cols = 40'h07_08_70_08_07;
      "Z":     cols = 40'h61_51_49_45_43;
      default: cols = '0;
    endcase
    return cols[39 - 8 * c -: 8];
  endfunction

  // one pixel into the shadow store, clipped to the panel
  function automatic void plot_pixel(input int px, input int py, input logic lit);
    int addr;
    if (px >= WIDTH_PX || py >= HEIGHT_PX) return;
    addr = px + (py / 8) * WIDTH_PX;
    shadow_fb[addr][py % 8] = lit;
  endfunction

  function automatic void wipe_shadow();
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
  endfunction

  // Update the shadow state for one accepted word, return the result it causes.
  function automatic result_word_t predict_result(input cmd_word_t w);
    result_word_t res;
    logic [7:0]   colbits;
    res.read_data = '0;
    res.drawn     = 1'b0;
    case (w.op)
      OP_SET: begin
        plot_pixel(w.x, w.y, w.on);
      end
      OP_CHAR: begin
        if (w.start) begin
          pen_col  = w.x;
          pen_row  = w.y;
          row_full = 1'b0;
        end
        if (!row_full) begin
          for (int c = 0; c < CELL_COLS; c++) begin
            colbits = font_col(w.ch, c);
            // the whole cell is written, dark pixels included; coords wrap at 256
            for (int r = 0; r < CELL_ROWS; r++)
              plot_pixel((pen_col + c) & 8'hFF, (pen_row + r) & 8'hFF, colbits[r]);
          end
          pen_col  = pen_col + 8'(CELL_ADVANCE);
          row_full = (int'(pen_col) + CELL_COLS >= WIDTH_PX);  // no wrap here
          res.drawn = 1'b1;
        end
      end
      OP_CLEAR: begin
        wipe_shadow();  // cursor state survives a clear
      end
      default: begin
        if (int'(w.bidx) < STORE_BYTES) res.read_data = shadow_fb[w.bidx];
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  function automatic cmd_word_t make_word(input op_t op, input int x, input int y,
                                          input bit on, input int ch, input bit start,
                                          input int bidx);
    cmd_word_t w;
    w.op    = op;
    w.x     = 8'(x);
    w.y     = 8'(y);
    w.on    = on;
    w.ch    = 8'(ch);
    w.start = start;
    w.bidx  = 10'(bidx);
    return w;
  endfunction

  // all fields random; callers override what matters
  function automatic cmd_word_t random_word();
    return make_word(op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 1),
                     $urandom_range(0, 255), $urandom_range(0, 1),
                     $urandom_range(0, 1023));
  endfunction

  // Present one word and hold it until accepted. tvalid stays high on return
  // so back-to-back words need no extra edge; a gap lowers it first.
  task automatic send_word(input cmd_word_t w);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.op;
    in_tdata  <= {4'b0, w.bidx, w.start, w.ch, w.on, w.y, w.x};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_result(w));
    words_sent++;
  endtask

  // stop sending until every outstanding result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side and checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t: result %0d %s: got %0h, expected %0h", $time, results_seen,
             what, got, want);
  endtask

  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[7:0] !== want.read_data)
          report_mismatch("read_data", out_tdata[7:0], want.read_data);
        if (out_tdata[8] !== want.drawn)
          report_mismatch("drawn", out_tdata[8], want.drawn);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // corners, clipping on each axis, lit and dark
  task automatic test_pixel_clipping();
    send_word(make_word(OP_SET, 0, 0, 1, 0, 0, 0));
    send_word(make_word(OP_SET, 127, 63, 1, 0, 0, 0));
    send_word(make_word(OP_SET, 128, 5, 1, 0, 0, 0));   // column off the right
    send_word(make_word(OP_SET, 3, 64, 1, 0, 0, 0));    // row off the bottom
    send_word(make_word(OP_SET, 255, 255, 1, 0, 0, 0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 1023));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 128));
    send_word(make_word(OP_SET, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0));
  endtask

  // glyphs, unknown codes, wrap, cursor advance and the full line
  task automatic test_glyph_strings();
    send_word(make_word(OP_CHAR, 0, 0, 0, "A", 1, 0));
    send_word(make_word(OP_CHAR, 0, 0, 0, 0, 0, 0));     // blank cell for code 0
    send_word(make_word(OP_CHAR, 0, 0, 0, 200, 0, 0));   // and for codes >= 128
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 2));
    // first char lands at the right edge: drawn, then the line is full
    send_word(make_word(OP_CHAR, 120, 60, 0, "8", 1, 0));
    send_word(make_word(OP_CHAR, 0, 0, 0, "1", 0, 0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 120 + 7 * WIDTH_PX));
    // fully clipped first char, cursor wraps to 0, rows wrap past 255
    send_word(make_word(OP_CHAR, 250, 254, 0, "M", 1, 0));
    send_word(make_word(OP_CHAR, 0, 0, 0, "Z", 0, 0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 1));
    // second char ends exactly at column 126, third is refused
    send_word(make_word(OP_CHAR, 116, 16, 0, "%", 1, 0));
    send_word(make_word(OP_CHAR, 0, 0, 0, ":", 0, 0));
    send_word(make_word(OP_CHAR, 0, 0, 0, "4", 0, 0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 123 + 2 * WIDTH_PX));
  endtask

  // clear wipes the store but keeps the full-line flag
  task automatic test_clear_and_readback();
    send_word(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_SET, 64, 32, 1, 0, 0, 0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 64 + 4 * WIDTH_PX));
    send_word(make_word(OP_CHAR, 10, 10, 0, "E", 0, 0));  // still refused
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------

  // byte address somewhere at or just after a drawing spot
  function automatic int addr_near(input int col, input int row);
    return ((col + $urandom_range(0, 30)) + ((row / 8) + $urandom_range(0, 1)) * WIDTH_PX)
           & 10'h3FF;
  endfunction

  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return FONT_CHARS[$urandom_range(0, FONT_CHARS.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // one string: mostly on the panel, sometimes wrapping or clipped
  task automatic string_burst();
    cmd_word_t w;
    int        col0, row0, n_chars;
    col0 = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 127);
    row0 = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 255) : $urandom_range(0, 63);
    n_chars = $urandom_range(1, 24);
    for (int i = 0; i < n_chars; i++) begin
      w       = random_word();
      w.op    = OP_CHAR;
      w.ch    = pick_char();
      w.start = 1'b0;
      if (i == 0) begin
        w.x = 8'(col0);
        w.y = 8'(row0);
        w.start = ($urandom_range(0, 9) != 0);  // sometimes continue the last line
      end
      send_word(w);
    end
    repeat ($urandom_range(1, 5)) begin
      w      = random_word();
      w.op   = OP_READ;
      w.bidx = 10'(addr_near(col0 + 6 * $urandom_range(0, n_chars), row0));
      send_word(w);
    end
  endtask

  task automatic pixel_burst();
    cmd_word_t w;
    int        col0, row0;
    col0 = $urandom_range(0, 135);
    row0 = $urandom_range(0, 71);
    repeat ($urandom_range(1, 8)) begin
      w    = random_word();
      w.op = OP_SET;
      w.x  = 8'(col0 + $urandom_range(0, 3));
      w.y  = 8'(row0 + $urandom_range(0, 9));
      if ($urandom_range(0, 19) == 0) w.y = 8'($urandom_range(0, 255));
      send_word(w);
    end
    w      = random_word();
    w.op   = OP_READ;
    w.bidx = 10'(addr_near(col0, row0) - $urandom_range(0, 27));
    send_word(w);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_words);
    cmd_word_t w;
    int        goal, roll;
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    goal = words_sent + n_words;
    while (words_sent < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        string_burst();
      end else if (roll < 70) begin
        pixel_burst();
      end else if (roll < 93) begin
        w    = random_word();
        w.op = OP_READ;
        send_word(w);
      end else if (roll < 98) begin
        send_word(random_word());  // noise, any op
      end else begin
        w    = random_word();
        w.op = OP_CLEAR;
        send_word(w);
      end
    end
    drain_results();  // sender holds off until the block is quiet
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    wipe_shadow();
    pen_col  = '0;
    pen_row  = '0;
    row_full = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;   // in_tready stays low through the clearing sweep

    test_pixel_clipping();
    test_glyph_strings();
    test_clear_and_readback();
    drain_results();

    test_random_traffic(0, 0, 225);
    test_random_traffic(58, 0, 225);
    test_random_traffic(0, 58, 225);
    test_random_traffic(8, 8, 225);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/pftr_pkg.sv
hdl/pftr_ctrl.sv
hdl/pftr_datapath.sv
hdl/page_framebuffer_text_renderer.sv
hdl/pftr_checker.sv
test/tb_page_framebuffer_text_renderer.sv
